### hdl/assert_macros.svh
// assertion macros shared by the histogram rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ewh_pkg.sv
// types and constants for the equal-width histogram
package ewh_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int TOTAL_W     = 11;
  localparam int INDEX_W     = 5;
  localparam int BIN_COUNT_W = 6;

  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 6'd10;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX       = 11'h7FF;

  // input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } ewh_in_t;

  // result transaction payload
  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic [TOTAL_W-1:0] bin_total;
    logic               last_bin;
  } ewh_out_t;

  // sequencer to bin scanner control
  typedef struct packed {
    logic start;
    logic last_bin;
  } ewh_scan_ctl_t;

endpackage

### hdl/ewh_ram.sv
// generic single-write, single-read ram with registered read data
module ewh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/ewh_div.sv
// iterative restoring divider, one quotient bit per cycle
module ewh_div #(
  parameter int DW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ewh_pkg::SAMPLE_W-1:0] dividend,
  input  logic [DW-1:0]                divisor,
  output logic                         done,
  output logic [ewh_pkg::SAMPLE_W-1:0] quotient
);

  localparam int SW     = ewh_pkg::SAMPLE_W;
  localparam int STEP_W = $clog2(SW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SW-1:0]     dvd_r, dvd_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic [DW:0]       trial;
  logic [DW:0]       trial_sub;
  logic              fits;

  // trial subtract of the shifted remainder
  assign trial     = {rem_r, dvd_r[SW-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      dvd_nxt  = {dvd_r[SW-2:0], fits};
      rem_nxt  = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### hdl/ewh_scan.sv
// sweeps the sample store once and counts samples that land in one bin
module ewh_scan #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ewh_pkg::ewh_scan_ctl_t              ctl,
  input  logic [CW-1:0]                       n_samples,
  input  logic signed [ewh_pkg::SAMPLE_W-1:0] lo,
  input  logic signed [ewh_pkg::SAMPLE_W-1:0] hi,
  output logic [AW-1:0]                       rd_addr,
  input  logic signed [ewh_pkg::SAMPLE_W-1:0] rd_data,
  output logic                                done,
  output logic [ewh_pkg::TOTAL_W-1:0]         total
);

  localparam int TW = ewh_pkg::TOTAL_W;

  logic          issue_r, issue_nxt;
  logic          vld_r, vld_nxt;
  logic          tail_r, tail_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic          issue_end;
  logic          hit;

  assign issue_end = (addr_r + CW'(1)) == n_samples;

  // bin membership: lower bound always, upper bound except on the last bin
  assign hit = (rd_data >= lo) && (ctl.last_bin || (rd_data < hi));

  always_comb begin
    issue_nxt = issue_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = issue_r;
    tail_nxt  = issue_r && issue_end;
    done_nxt  = vld_r && tail_r;
    // address issue
    if (issue_r) begin
      addr_nxt = addr_r + CW'(1);
      if (issue_end) begin
        issue_nxt = 1'b0;
      end
    end
    // saturating count on returned data
    if (vld_r && hit && (cnt_r != ewh_pkg::TOTAL_MAX)) begin
      cnt_nxt = cnt_r + TW'(1);
    end
    if (ctl.start) begin
      issue_nxt = 1'b1;
      addr_nxt  = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      vld_r   <= 1'b0;
      tail_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      issue_r <= issue_nxt;
      vld_r   <= vld_nxt;
      tail_r  <= tail_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rd_addr = addr_r[AW-1:0];
  assign done    = done_r;
  assign total   = cnt_r;

endmodule

### hdl/equal_width_histogram.sv
// equal-width histogram: sample store, min/max tracking, width divider, bin sweeps
// samples load at one per cycle while in_ready is high (store write port)
// after the closing sample: the width divide, then for each of the n bins one
// full store sweep over the N stored samples plus the result handshake
// reset: sync active low, clears sequencer, counts and extremes, bin_count to 10
`include "assert_macros.svh"

module equal_width_histogram #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_BINS    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ewh_pkg::ewh_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ewh_pkg::ewh_out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ewh_pkg::BIN_COUNT_W-1:0]      cfg_data
);

  localparam int SW  = ewh_pkg::SAMPLE_W;
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int NW  = $clog2(MAX_BINS + 1);
  localparam int JW  = (NW > ewh_pkg::BIN_COUNT_W) ? NW : ewh_pkg::BIN_COUNT_W;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic signed [SW-1:0]                min_r, min_nxt;
  logic signed [SW-1:0]                max_r, max_nxt;
  logic [JW-1:0]                       bins_r, bins_nxt;
  logic [JW-1:0]                       j_r, j_nxt;
  logic [ewh_pkg::BIN_COUNT_W-1:0]     bin_count_r, bin_count_nxt;
  logic                                div_go_r, div_go_nxt;
  logic                                scan_go_r, scan_go_nxt;
  logic                                out_valid_r, out_valid_nxt;
  ewh_pkg::ewh_out_t                   out_data_r, out_data_nxt;
  logic [SW-1:0]                       w_r, w_nxt;
  logic signed [SW-1:0]                lo_r, lo_nxt;
  logic signed [SW-1:0]                hi_r, hi_nxt;

  logic                                in_accept;
  logic                                store_ok;
  logic [JW-1:0]                       n_eff;
  logic [SW:0]                         diff_ext;
  logic                                div_done;
  logic [SW-1:0]                       quot;
  logic signed [SW-1:0]                add_a;
  logic [SW-1:0]                       add_b;
  logic [SW:0]                         sum_ext;
  logic signed [SW-1:0]                bound_sum;
  logic                                is_last_j;
  ewh_pkg::ewh_scan_ctl_t              scan_ctl;
  logic [AW-1:0]                       rd_addr;
  logic [SW-1:0]                       rd_data;
  logic                                scan_done;
  logic [ewh_pkg::TOTAL_W-1:0]         scan_total;

  assign in_ready  = state_r == S_LOAD;
  assign in_accept = in_valid && in_ready;
  assign store_ok  = cnt_r != CW'(MAX_SAMPLES);
  assign cfg_ready = 1'b1;

  // effective bin count: zero means one, saturate at MAX_BINS
  always_comb begin
    if (bin_count_r == '0) begin
      n_eff = JW'(1);
    end else if (int'(bin_count_r) > MAX_BINS) begin
      n_eff = JW'(MAX_BINS);
    end else begin
      n_eff = JW'(bin_count_r);
    end
  end

  // range of the run, never negative
  assign diff_ext = {max_r[SW-1], max_r} - {min_r[SW-1], min_r};

  // shared bound adder: first bin edge from min, later edges step by width
  assign add_a     = (state_r == S_DIV) ? min_r : hi_r;
  assign add_b     = (state_r == S_DIV) ? quot : w_r;
  assign sum_ext   = {add_a[SW-1], add_a} + {1'b0, add_b};
  assign bound_sum = sum_ext[SW-1:0];

  assign is_last_j = j_r == (bins_r - JW'(1));

  assign scan_ctl.start    = scan_go_r;
  assign scan_ctl.last_bin = is_last_j;

  // sample store
  ewh_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_accept && store_ok),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_data.sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // bin width divider
  ewh_div #(
    .DW (JW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (diff_ext[SW-1:0]),
    .divisor  (bins_r),
    .done     (div_done),
    .quotient (quot)
  );

  // per-bin store sweep
  ewh_scan #(
    .AW (AW),
    .CW (CW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .n_samples (cnt_r),
    .lo        (lo_r),
    .hi        (hi_r),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (scan_done),
    .total     (scan_total)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    bins_nxt      = bins_r;
    j_nxt         = j_r;
    div_go_nxt    = 1'b0;
    scan_go_nxt   = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bin_count_nxt = cfg_valid ? cfg_data : bin_count_r;
    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          // store and track extremes unless full
          if (store_ok) begin
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              min_nxt = in_data.sample;
              max_nxt = in_data.sample;
            end else begin
              if (in_data.sample < min_r) begin
                min_nxt = in_data.sample;
              end
              if (in_data.sample > max_r) begin
                max_nxt = in_data.sample;
              end
            end
          end
          if (in_data.last_sample) begin
            bins_nxt   = n_eff;
            div_go_nxt = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          w_nxt       = quot;
          lo_nxt      = min_r;
          hi_nxt      = bound_sum;
          j_nxt       = '0;
          scan_go_nxt = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.bin_index = j_r[ewh_pkg::INDEX_W-1:0];
          out_data_nxt.bin_total = scan_total;
          out_data_nxt.last_bin  = is_last_j;
          state_nxt              = S_OUT;
        end
      end
      S_OUT: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last_bin) begin
            // run closed, start fresh
            cnt_nxt   = '0;
            min_nxt   = '0;
            max_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt       = j_r + JW'(1);
            lo_nxt      = hi_r;
            hi_nxt      = bound_sum;
            scan_go_nxt = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      bins_r      <= JW'(1);
      j_r         <= '0;
      bin_count_r <= ewh_pkg::BIN_COUNT_RESET;
      div_go_r    <= 1'b0;
      scan_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      bins_r      <= bins_nxt;
      j_r         <= j_nxt;
      bin_count_r <= bin_count_nxt;
      div_go_r    <= div_go_nxt;
      scan_go_r   <= scan_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(MAX_SAMPLES), "stored count beyond capacity")
  `ASSERT_IMPL(a_min_le_max, cnt_r != '0, min_r <= max_r, "minimum above maximum")
  `ASSERT_IMPL(a_out_state, out_valid_r, state_r == S_OUT, "result shown outside output state")
  `ASSERT_NEXT(a_run_clear, out_valid && out_ready && out_data.last_bin, cnt_r == '0, "run not cleared")

endmodule

### sim/ewh_checker.sv
// bin-total predictor and result checker for the equal-width histogram
`timescale 1ns / 1ps

module ewh_checker #(
  parameter int STORE_DEPTH = 1024,
  parameter int BIN_LIMIT   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ewh_pkg::ewh_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ewh_pkg::ewh_out_t               out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ewh_pkg::BIN_COUNT_W-1:0] cfg_data,
  output int                              mismatch_total,
  output int                              totals_waiting
);

  // predictor state for the run in progress
  logic signed [ewh_pkg::SAMPLE_W-1:0] run_samples [STORE_DEPTH];
  int                                  run_len;
  logic signed [ewh_pkg::SAMPLE_W-1:0] run_min;
  logic signed [ewh_pkg::SAMPLE_W-1:0] run_max;
  logic [ewh_pkg::BIN_COUNT_W-1:0]     bins_setting;
  ewh_pkg::ewh_out_t                   totals_due [$];
  int                                  mismatches;

  // close the run: bin every stored sample and queue the totals in bin order
  task automatic bin_run();
    int                n;
    int                i;
    int                j;
    longint            width;
    longint            left;
    longint            right;
    longint            v;
    bit                placed;
    int                tally [BIN_LIMIT];
    ewh_pkg::ewh_out_t item;
    n = (bins_setting == 0) ? 1 : ((bins_setting > BIN_LIMIT) ? BIN_LIMIT : int'(bins_setting));
    width = (longint'(run_max) - longint'(run_min)) / n;
    tally = '{default: 0};
    for (i = 0; i < run_len; i++) begin
      v = longint'(run_samples[i]);
      placed = 1'b0;
      for (j = 0; j < n && !placed; j++) begin
        left = longint'(run_min) + longint'(j) * width;
        right = left + width;
        if (v >= left && v < right) begin
          placed = 1'b1;
          if (tally[j] < int'(ewh_pkg::TOTAL_MAX)) tally[j]++;
        end
      end
      // outside every bin (at or above the top edge, or zero width): last bin
      if (!placed && tally[n-1] < int'(ewh_pkg::TOTAL_MAX)) tally[n-1]++;
    end
    for (j = 0; j < n; j++) begin
      item.bin_index = j[ewh_pkg::INDEX_W-1:0];
      item.bin_total = tally[j][ewh_pkg::TOTAL_W-1:0];
      item.last_bin  = (j == n - 1);
      totals_due.push_back(item);
    end
    run_len = 0;
    run_min = '0;
    run_max = '0;
  endtask

  // store one accepted sample, drop it when the store is full
  task automatic take_sample(input ewh_pkg::ewh_in_t item);
    if (run_len < STORE_DEPTH) begin
      if (run_len == 0) begin
        run_min = item.sample;
        run_max = item.sample;
      end else begin
        if (item.sample < run_min) run_min = item.sample;
        if (item.sample > run_max) run_max = item.sample;
      end
      run_samples[run_len] = item.sample;
      run_len++;
    end
    if (item.last_sample) bin_run();
  endtask

  // compare one result transaction with the oldest expected total
  task automatic check_total(input ewh_pkg::ewh_out_t got);
    ewh_pkg::ewh_out_t want;
    if (totals_due.size() == 0) begin
      $display("%0t: unexpected result bin_index %0d bin_total %0d last_bin %0b",
               $time, got.bin_index, got.bin_total, got.last_bin);
      mismatches++;
    end else begin
      want = totals_due.pop_front();
      if (got.bin_index !== want.bin_index) begin
        $display("%0t: bin_index expected %0d actual %0d",
                 $time, want.bin_index, got.bin_index);
        mismatches++;
      end
      if (got.bin_total !== want.bin_total) begin
        $display("%0t: bin_total of bin %0d expected %0d actual %0d",
                 $time, want.bin_index, want.bin_total, got.bin_total);
        mismatches++;
      end
      if (got.last_bin !== want.last_bin) begin
        $display("%0t: last_bin of bin %0d expected %0b actual %0b",
                 $time, want.bin_index, want.last_bin, got.last_bin);
        mismatches++;
      end
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      run_len = 0;
      run_min = '0;
      run_max = '0;
      bins_setting = ewh_pkg::BIN_COUNT_RESET;
      totals_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) check_total(out_data);
      if (cfg_valid && cfg_ready) bins_setting = cfg_data;
      if (in_valid && in_ready) take_sample(in_data);
    end
    mismatch_total <= mismatches;
    totals_waiting <= totals_due.size();
  end

endmodule

### sim/tb_top.sv
// testbench top: stimulus, idling, hold-off and verdict for the equal-width histogram
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = 1024;
  localparam int BIN_LIMIT   = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 40;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  ewh_pkg::ewh_in_t                in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ewh_pkg::ewh_out_t               out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ewh_pkg::BIN_COUNT_W-1:0] cfg_data  = '0;

  int mismatch_total;
  int totals_waiting;
  int cycle_count = 0;
  bit idle_on     = 1'b1;
  bit hold_out    = 1'b0;

  equal_width_histogram #(
    .MAX_SAMPLES(STORE_DEPTH),
    .MAX_BINS   (BIN_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ewh_checker #(
    .STORE_DEPTH(STORE_DEPTH),
    .BIN_LIMIT  (BIN_LIMIT)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_total(mismatch_total),
    .totals_waiting(totals_waiting)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ready <= !(idle_on && ($urandom_range(99) < 14));
      end
    end
  end

  // offer one sample transaction and wait until it is taken
  task automatic push_sample(input logic [31:0] val, input logic last);
    if (idle_on && ($urandom_range(99) < 14)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= val;
    in_data.last_sample <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // one run from a list, flagged on its final sample
  task automatic send_values(input logic [31:0] vals [$]);
    int i;
    for (i = 0; i < vals.size(); i++) push_sample(vals[i], i == vals.size() - 1);
  endtask

  // stop offering, wait for every expected total, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (totals_waiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // bin_count write transaction, only while the block is idle
  task automatic write_bin_count(input logic [ewh_pkg::BIN_COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random runs: mostly short, with spread, clustered, equal and extreme values
  task automatic random_runs(input int quota);
    int          sent;
    int          len;
    int          mode;
    int          i;
    logic [31:0] base;
    logic [31:0] val;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      mode = $urandom_range(4);
      base = $urandom();
      for (i = 0; i < len; i++) begin
        case (mode)
          0: val = $urandom();
          1: val = base + $urandom_range(255);
          2: val = base + ($urandom_range(15) << 16);
          3: val = base;
          default: begin
            case ($urandom_range(3))
              0: val = 32'h8000_0000;
              1: val = 32'h7FFF_FFFF;
              2: val = 32'h0000_0000;
              default: val = $urandom();
            endcase
          end
        endcase
        push_sample(val, i == len - 1);
      end
      sent += len;
    end
  endtask

  // stimulus and verdict
  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bin count: single sample, full range, equal samples, exact boundaries
    send_values('{32'h7FFF_FFFF});
    send_values('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF});
    send_values('{32'h0003_0000, 32'h0003_0000, 32'h0003_0000});
    for (k = 0; k <= 10; k++) push_sample(k << 16, k == 10);
    drain();

    // zero bins act as one
    write_bin_count(6'd0);
    send_values('{32'hFFFB_0000, 32'h0007_8000, 32'h0000_0001});
    drain();

    // top value saturates to the bin limit
    write_bin_count(6'd63);
    send_values('{32'h0000_0000, 32'h0000_0010, 32'h0000_001F, 32'h0000_0020});
    drain();

    write_bin_count(6'd1);
    random_runs(70);
    drain();

    // long stretch with no idling on either side
    idle_on = 1'b0;
    write_bin_count(6'd32);
    random_runs(70);
    drain();
    idle_on = 1'b1;

    write_bin_count(6'd33);
    random_runs(60);
    drain();

    // receiver holds off while runs keep coming, so the input stalls
    write_bin_count(6'd31);
    hold_out = 1'b1;
    random_runs(40);
    drain();

    for (k = 0; k < 4; k++) begin
      write_bin_count(ewh_pkg::BIN_COUNT_W'($urandom_range(63)));
      random_runs(40);
      drain();
    end

    if (mismatch_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
